FILE: rtl/ist_pkg.sv
package ist_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned FracW = 16;
  localparam logic [31:0] OneQ  = 32'h0001_0000;

  localparam logic [1:0] ACT_STEP  = 2'd0;
  localparam logic [1:0] ACT_DELTA = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;

  localparam logic [1:0] CASE_INVALID = 2'd0;
  localparam logic [1:0] CASE_NEG     = 2'd1;
  localparam logic [1:0] CASE_SLIDE   = 2'd2;
  localparam logic [1:0] CASE_POS     = 2'd3;

  localparam logic [1:0] REG_GAIN_ONE = 2'd0;
  localparam logic [1:0] REG_GAIN_TWO = 2'd1;
  localparam logic [1:0] REG_BOUNDARY = 2'd2;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_DELTA,
    OP_CLEAR,
    OP_ZERO,
    OP_MUL_XX,
    OP_DIV_BL,
    OP_DIV_Q,
    OP_DIV_STEP,
    OP_BL_DONE,
    OP_M1,
    OP_M2,
    OP_M3,
    OP_M4,
    OP_M5,
    OP_M6,
    OP_B,
    OP_CASE,
    OP_DISC,
    OP_SQ_STEP,
    OP_TERM,
    OP_NU,
    OP_U,
    OP_QU,
    OP_OUT
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic [1:0] action;
    logic       h_zero;
    logic       eps_zero;
    logic [1:0] case_code;
  } status_t;

  // clamp to the signed 32-bit range
  function automatic logic [31:0] sat34(input logic [33:0] v);
    logic [31:0] res;
    if (v[33:31] == 3'b000 || v[33:31] == 3'b111) res = v[31:0];
    else if (v[33]) res = 32'h8000_0000;
    else res = 32'h7fff_ffff;
    return res;
  endfunction

  function automatic logic [31:0] sat50(input logic [49:0] v);
    logic [31:0] res;
    if (v[49:31] == '0 || v[49:31] == '1) res = v[31:0];
    else if (v[49]) res = 32'h8000_0000;
    else res = 32'h7fff_ffff;
    return res;
  endfunction

endpackage

FILE: rtl/ist_ctrl.sv
module ist_ctrl
  import ist_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_fire,
  input  logic    out_tready,
  input  status_t status,
  output cmd_t    cmd,
  output logic    in_tready,
  output logic    out_tvalid
);

  typedef enum logic [21:0] {
    S_IDLE = 22'b1 << 0,
    S_DISP = 22'b1 << 1,
    S_XX   = 22'b1 << 2,
    S_DIVI = 22'b1 << 3,
    S_DIV  = 22'b1 << 4,
    S_BLD  = 22'b1 << 5,
    S_M1   = 22'b1 << 6,
    S_M2   = 22'b1 << 7,
    S_M3   = 22'b1 << 8,
    S_M4   = 22'b1 << 9,
    S_M5   = 22'b1 << 10,
    S_M6   = 22'b1 << 11,
    S_B    = 22'b1 << 12,
    S_CASE = 22'b1 << 13,
    S_SEL  = 22'b1 << 14,
    S_SQ   = 22'b1 << 15,
    S_TERM = 22'b1 << 16,
    S_NU   = 22'b1 << 17,
    S_U    = 22'b1 << 18,
    S_QDIV = 22'b1 << 19,
    S_QU   = 22'b1 << 20,
    S_OUT  = 22'b1 << 21
  } state_t;

  state_t     state_r, state_nxt;
  logic [5:0] cnt_r, cnt_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = '0;
    out_valid_nxt = out_valid_r && !out_tready;
    cmd.op        = OP_NONE;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        state_nxt = S_IDLE;
        case (status.action)
          ACT_STEP: begin
            if (status.h_zero) begin
              cmd.op    = OP_ZERO;
              state_nxt = S_OUT;
            end else if (status.eps_zero) begin
              state_nxt = S_M1;
            end else begin
              state_nxt = S_XX;
            end
          end
          ACT_DELTA: cmd.op = OP_DELTA;
          ACT_CLEAR: cmd.op = OP_CLEAR;
          default: cmd.op = OP_NONE;
        endcase
      end
      S_XX: begin
        cmd.op    = OP_MUL_XX;
        state_nxt = S_DIVI;
      end
      S_DIVI: begin
        cmd.op    = OP_DIV_BL;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.op  = OP_DIV_STEP;
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd63) state_nxt = S_BLD;
      end
      S_BLD: begin
        cmd.op    = OP_BL_DONE;
        state_nxt = S_M1;
      end
      S_M1: begin
        cmd.op    = OP_M1;
        state_nxt = S_M2;
      end
      S_M2: begin
        cmd.op    = OP_M2;
        state_nxt = S_M3;
      end
      S_M3: begin
        cmd.op    = OP_M3;
        state_nxt = S_M4;
      end
      S_M4: begin
        cmd.op    = OP_M4;
        state_nxt = S_M5;
      end
      S_M5: begin
        cmd.op    = OP_M5;
        state_nxt = S_M6;
      end
      S_M6: begin
        cmd.op    = OP_M6;
        state_nxt = S_B;
      end
      S_B: begin
        cmd.op    = OP_B;
        state_nxt = S_CASE;
      end
      S_CASE: begin
        cmd.op    = OP_CASE;
        state_nxt = S_SEL;
      end
      S_SEL: begin
        if (status.case_code == CASE_SLIDE) begin
          cmd.op    = OP_DIV_Q;
          state_nxt = S_QDIV;
        end else begin
          cmd.op    = OP_DISC;
          state_nxt = S_SQ;
        end
      end
      S_SQ: begin
        cmd.op  = OP_SQ_STEP;
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd31) state_nxt = S_TERM;
      end
      S_TERM: begin
        cmd.op    = OP_TERM;
        state_nxt = S_NU;
      end
      S_NU: begin
        cmd.op    = OP_NU;
        state_nxt = S_U;
      end
      S_U: begin
        cmd.op    = OP_U;
        state_nxt = S_OUT;
      end
      S_QDIV: begin
        cmd.op  = OP_DIV_STEP;
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd63) state_nxt = S_QU;
      end
      S_QU: begin
        cmd.op    = OP_QU;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        // wait for the output slot to free up
        if (!out_valid_r || out_tready) begin
          cmd.op        = OP_OUT;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

endmodule

FILE: rtl/ist_datapath.sv
module ist_datapath
  import ist_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  input  logic [1:0]  in_action,
  input  logic [31:0] in_x,
  input  logic [31:0] in_h,
  input  logic [31:0] in_delta,
  input  logic [31:0] gain_one,
  input  logic [31:0] gain_two,
  input  logic [31:0] boundary_width,
  output status_t     status,
  output logic [31:0] drive,
  output logic [1:0]  case_taken
);

  logic [1:0]  action_r;
  logic [31:0] x_r, h_r, delta_r, axe_r;
  logic [31:0] nu_r, nu_nxt;
  logic [63:0] mul_r;
  logic [31:0] a_r, hnu_r, t_r, dnu_r;
  logic [33:0] b_r, c_r;
  logic [1:0]  case_r;
  logic [63:0] num_r;
  logic [32:0] den_r, rem_r;
  logic [63:0] sv_r, sr_r, sbit_r;
  logic [31:0] res_drive_r;
  logic [1:0]  res_case_r;
  logic [31:0] drive_r;
  logic [1:0]  case_out_r;

  logic [31:0] l1e, l2e, ax, nu_mag, s_val, qc;
  logic [31:0] mul_a, mul_b;
  logic        xneg;
  logic [33:0] rem_sh, xe_s, hnu_s, t_s, b_cur, nu34, u34;
  logic [64:0] sq_sum, disc_sum;
  logic        sq_ge, div_ge;
  logic [32:0] root;
  logic [49:0] u50;

  assign l1e    = (gain_one == '0) ? OneQ : gain_one;
  assign l2e    = (gain_two == '0) ? OneQ : gain_two;
  assign xneg   = x_r[31];
  assign ax     = xneg ? (32'd0 - x_r) : x_r;
  assign nu_mag = nu_r[31] ? (32'd0 - nu_r) : nu_r;

  // restoring divide step
  assign rem_sh = {rem_r, num_r[63]};
  assign div_ge = rem_sh >= {1'b0, den_r};

  // square root step
  assign sq_sum = {1'b0, sr_r} + {1'b0, sbit_r};
  assign sq_ge  = {1'b0, sv_r} >= sq_sum;

  // s = (sqrt(disc) - a) / 2, floored at zero
  assign root  = sr_r[32:0];
  assign s_val = (root > {1'b0, a_r}) ? 32'((root - {1'b0, a_r}) >> 1) : 32'd0;

  assign xe_s  = xneg ? (34'd0 - {2'b0, axe_r}) : {2'b0, axe_r};
  assign hnu_s = nu_r[31] ? (34'd0 - {2'b0, hnu_r}) : {2'b0, hnu_r};
  assign b_cur = 34'd0 - xe_s - hnu_s;
  assign t_s   = {2'b0, t_r};

  assign disc_sum = {1'b0, mul_r} + {13'b0, c_r, 18'b0};

  assign nu34 = (case_r == CASE_NEG) ? ({{2{nu_r[31]}}, nu_r} - {2'b0, dnu_r})
                                     : ({{2{nu_r[31]}}, nu_r} + {2'b0, dnu_r});
  assign u50  = (case_r == CASE_NEG) ? ({{18{nu_r[31]}}, nu_r} - {2'b0, mul_r[63:16]})
                                     : ({{18{nu_r[31]}}, nu_r} + {2'b0, mul_r[63:16]});

  assign qc  = (num_r > 64'h8000_0000) ? 32'h8000_0000 : num_r[31:0];
  assign u34 = xneg ? {2'b0, qc} : (34'd0 - {2'b0, qc});

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_MUL_XX: begin mul_a = ax;     mul_b = ax;           end
      OP_M1:     begin mul_a = l1e;    mul_b = h_r;          end
      OP_M2:     begin mul_a = nu_mag; mul_b = h_r;          end
      OP_M3:     begin mul_a = h_r;    mul_b = h_r;          end
      OP_M4:     begin mul_a = l2e;    mul_b = mul_r[63:32]; end
      OP_M5:     begin mul_a = l2e;    mul_b = h_r;          end
      OP_M6:     begin mul_a = a_r;    mul_b = a_r;          end
      OP_TERM:   begin mul_a = l1e;    mul_b = s_val;        end
      default:   begin mul_a = '0;     mul_b = '0;           end
    endcase
  end

  always_comb begin
    nu_nxt = nu_r;
    case (cmd.op)
      OP_DELTA: nu_nxt = sat34({{2{nu_r[31]}}, nu_r} + {{2{delta_r[31]}}, delta_r});
      OP_CLEAR: nu_nxt = '0;
      OP_NU:    nu_nxt = sat34(nu34);
      OP_QU:    nu_nxt = sat34(u34);
      default:  nu_nxt = nu_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nu_r <= '0;
    end else begin
      nu_r <= nu_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        action_r <= in_action;
        x_r      <= in_x;
        h_r      <= in_h;
        delta_r  <= in_delta;
        axe_r    <= in_x[31] ? (32'd0 - in_x) : in_x;
      end
      OP_ZERO: begin
        res_drive_r <= '0;
        res_case_r  <= CASE_INVALID;
      end
      OP_DIV_BL: begin
        num_r <= mul_r;
        den_r <= {1'b0, ax} + {1'b0, boundary_width};
        rem_r <= '0;
      end
      OP_DIV_Q: begin
        num_r <= {axe_r, 32'd0};
        den_r <= {1'b0, h_r};
        rem_r <= '0;
      end
      OP_DIV_STEP: begin
        rem_r <= div_ge ? 33'(rem_sh - {1'b0, den_r}) : rem_sh[32:0];
        num_r <= {num_r[62:0], div_ge};
      end
      OP_BL_DONE: axe_r <= num_r[31:0];
      OP_M2:      a_r   <= mul_r[63:32];
      OP_M3:      hnu_r <= mul_r[63:32];
      OP_M5:      t_r   <= mul_r[63:32];
      OP_M6:      dnu_r <= mul_r[63:32];
      OP_B:       b_r   <= b_cur;
      OP_CASE: begin
        if ($signed(b_r) < -$signed(t_s)) begin
          case_r <= CASE_NEG;
          c_r    <= 34'd0 - (b_r + t_s);
        end else if ($signed(b_r) > $signed(t_s)) begin
          case_r <= CASE_POS;
          c_r    <= b_r - t_s;
        end else begin
          case_r <= CASE_SLIDE;
          c_r    <= '0;
        end
      end
      OP_DISC: begin
        sv_r   <= disc_sum[64] ? '1 : disc_sum[63:0];
        sr_r   <= '0;
        sbit_r <= 64'h4000_0000_0000_0000;
      end
      OP_SQ_STEP: begin
        if (sq_ge) begin
          sv_r <= sv_r - sq_sum[63:0];
          sr_r <= (sr_r >> 1) + sbit_r;
        end else begin
          sr_r <= sr_r >> 1;
        end
        sbit_r <= sbit_r >> 2;
      end
      OP_U: begin
        res_drive_r <= sat50(u50);
        res_case_r  <= case_r;
      end
      OP_QU: begin
        res_drive_r <= sat34(u34);
        res_case_r  <= CASE_SLIDE;
      end
      OP_OUT: begin
        drive_r    <= res_drive_r;
        case_out_r <= res_case_r;
      end
      default: ;
    endcase
    case (cmd.op)
      OP_MUL_XX, OP_M1, OP_M2, OP_M3, OP_M4, OP_M5, OP_M6, OP_TERM:
        mul_r <= mul_a * mul_b;
      default: ;
    endcase
  end

  assign status.action    = action_r;
  assign status.h_zero    = (h_r == '0);
  assign status.eps_zero  = (boundary_width == '0);
  assign status.case_code = case_r;
  assign drive            = drive_r;
  assign case_taken       = case_out_r;

endmodule

FILE: rtl/implicit_super_twisting_step.sv
// Implicit super-twisting sliding-mode controller step, Q16.16 fixed point.
// Input stream: in_tuser carries the action (0 control step, 1 add nu_delta to
// the integral term nu, 2 clear nu), in_tdata carries x, h and nu_delta.
// Only a control step yields a result item on the out_ stream: drive (u) in
// out_tdata and the branch taken in out_tuser.
// One item is in work at a time; in_tready is high only when the block is idle.
// Zero h skips the computation; actions 1 and 2 yield no result.
// Branches 1 and 3 take the square root (one root bit a cycle), the
// sliding branch a restoring divide (one quotient bit a cycle); a
// nonzero boundary width adds a further restoring divide before either.
// A single 32x32 multiplier serves all products in turn.
// A finished result sits in the output register until out_tready; the next
// item is accepted meanwhile, but its result waits for the register to free.
// Synchronous active-low reset: gains read 1.0, boundary width 0, nu 0,
// no result pending. Gains and boundary width are written over the cfg_ port
// (byte addresses 0, 4, 8); the user must write them only while the block
// is idle, as the block itself does not enforce it.
module implicit_super_twisting_step
  import ist_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // sliding_var, time_step, nu_delta
  input  logic [1:0]  in_tuser,   // action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // drive
  output logic [1:0]  out_tuser,  // case_taken
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [31:0] gain_one_r, gain_two_r, boundary_r;
  logic        cfg_wr;
  cmd_t        cmd;
  status_t     status;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_one_r <= OneQ;
      gain_two_r <= OneQ;
      boundary_r <= '0;
    end else if (cfg_wr) begin
      case (cfg_paddr[3:2])
        REG_GAIN_ONE: gain_one_r <= cfg_pwdata;
        REG_GAIN_TWO: gain_two_r <= cfg_pwdata;
        REG_BOUNDARY: boundary_r <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      REG_GAIN_ONE: cfg_prdata = gain_one_r;
      REG_GAIN_TWO: cfg_prdata = gain_two_r;
      REG_BOUNDARY: cfg_prdata = boundary_r;
      default:      cfg_prdata = '0;
    endcase
  end

  ist_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_tvalid && in_tready),
    .out_tready(out_tready),
    .status    (status),
    .cmd       (cmd),
    .in_tready (in_tready),
    .out_tvalid(out_tvalid)
  );

  ist_datapath u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .in_action     (in_tuser),
    .in_x          (in_tdata[31:0]),
    .in_h          (in_tdata[63:32]),
    .in_delta      (in_tdata[95:64]),
    .gain_one      (gain_one_r),
    .gain_two      (gain_two_r),
    .boundary_width(boundary_r),
    .status        (status),
    .drive         (out_tdata),
    .case_taken    (out_tuser)
  );

endmodule

FILE: rtl/ist_checker.sv
module ist_sva_checker
  import ist_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [95:0] in_tdata,
  input logic [1:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic [1:0]  out_tuser,
  input logic        cfg_psel,
  input logic        cfg_penable,
  input logic        cfg_pwrite,
  input logic [3:0]  cfg_paddr,
  input logic [31:0] cfg_pwdata,
  input logic [31:0] cfg_prdata,
  input logic        cfg_pready
);

  // a result waits until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result item dropped while stalled");

  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result item pending after reset");

  // invalid step always drives zero
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == CASE_INVALID |-> out_tdata == '0)
    else $error("invalid step with nonzero drive");

  a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_paddr == 4'd0
    |=> cfg_paddr != 4'd0 || cfg_prdata == $past(cfg_pwdata))
    else $error("gain_one readback mismatch");

endmodule

bind implicit_super_twisting_step ist_sva_checker u_ist_checker (.*);
